>>> design/binary_semaphore_table_defines.svh
// assertion macros used by the port checker
`ifndef BINARY_SEMAPHORE_TABLE_DEFINES_SVH
`define BINARY_SEMAPHORE_TABLE_DEFINES_SVH

// same-cycle implication
`define BST_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("binary_semaphore_table check failed");

// next-cycle implication
`define BST_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("binary_semaphore_table check failed");

`endif

>>> design/bst_pkg.sv
`timescale 1ns / 1ps

package bst_pkg;

    localparam int SEM_COUNT_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int FIELD_W = 8;

    typedef logic [1:0] cmd_t;
    typedef logic [1:0] status_t;

    localparam cmd_t CMD_CREATE = 2'd0;
    localparam cmd_t CMD_DOWN   = 2'd1;
    localparam cmd_t CMD_UP     = 2'd2;
    localparam cmd_t CMD_CLEAR  = 2'd3;

    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_BAD_ID     = 2'd1;
    localparam status_t ST_NO_FREE    = 2'd2;
    localparam status_t ST_QUEUE_FULL = 2'd3;

    typedef struct packed {
        cmd_t               cmd;
        logic [FIELD_W-1:0] sem_id;
        logic [FIELD_W-1:0] requester_id;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [FIELD_W-1:0] new_sem_id;
        logic               blocked;
        logic               woken_valid;
    } res_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ring_ctl_t;

    function automatic int clog2_min1(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

>>> design/bst_free_enc.sv
`timescale 1ns / 1ps

module bst_free_enc #(
    parameter int SEM_COUNT = bst_pkg::SEM_COUNT_DEF,
    parameter int IDX_W     = bst_pkg::clog2_min1(SEM_COUNT)
) (
    input  logic [SEM_COUNT-1:0] in_use,
    output logic                 found,
    output logic [IDX_W-1:0]     free_idx
);

    // lowest entry not in use wins
    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = SEM_COUNT - 1; i >= 0; i--) begin
            if (!in_use[i]) begin
                found    = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

endmodule

>>> design/bst_wait_ring.sv
`timescale 1ns / 1ps

module bst_wait_ring #(
    parameter int AW = 7
) (
    input  logic                        aclk,
    input  bst_pkg::ring_ctl_t          ctl,
    input  logic [AW-1:0]               wr_addr,
    input  logic [bst_pkg::FIELD_W-1:0] wr_data,
    input  logic [AW-1:0]               rd_addr,
    output logic [bst_pkg::FIELD_W-1:0] rd_data
);

    logic [bst_pkg::FIELD_W-1:0] mem [1 << AW];
    logic [bst_pkg::FIELD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/bst_sem_table.sv
`timescale 1ns / 1ps

module bst_sem_table #(
    parameter int SEM_COUNT   = bst_pkg::SEM_COUNT_DEF,
    parameter int QUEUE_DEPTH = bst_pkg::QUEUE_DEPTH_DEF,
    parameter int IDX_W       = bst_pkg::clog2_min1(SEM_COUNT),
    parameter int PW          = bst_pkg::clog2_min1(QUEUE_DEPTH)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  bst_pkg::in_item_t           item,
    output bst_pkg::res_t               res,
    output bst_pkg::ring_ctl_t          ring_ctl,
    output logic [IDX_W+PW-1:0]         ring_wr_addr,
    output logic [IDX_W+PW-1:0]         ring_rd_addr,
    output logic [bst_pkg::FIELD_W-1:0] ring_wr_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [SEM_COUNT-1:0] in_use_reg;
    logic [SEM_COUNT-1:0] avail_reg;
    logic [PW-1:0]        wpos_reg [SEM_COUNT];
    logic [PW-1:0]        rpos_reg [SEM_COUNT];
    logic [CW-1:0]        cnt_reg  [SEM_COUNT];

    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             id_ok;
    logic [IDX_W-1:0] idx;
    logic             cur_use;
    logic             cur_avail;
    logic [PW-1:0]    cur_wpos;
    logic [PW-1:0]    cur_rpos;
    logic [CW-1:0]    cur_cnt;
    logic             q_full;
    logic             q_empty;
    logic             do_create;
    logic             do_clear;
    logic             do_take;
    logic             do_queue;
    logic             do_wake;
    logic             do_give;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] pos);
        logic [PW:0] inc;
        inc = {1'b0, pos} + (PW + 1)'(1);
        return (inc >= (PW + 1)'(QUEUE_DEPTH)) ? '0 : inc[PW-1:0];
    endfunction

    bst_free_enc #(
        .SEM_COUNT (SEM_COUNT),
        .IDX_W     (IDX_W)
    ) u_free_enc (
        .in_use   (in_use_reg),
        .found    (free_found),
        .free_idx (free_idx)
    );

    assign id_ok     = {1'b0, item.sem_id} < (bst_pkg::FIELD_W + 1)'(SEM_COUNT);
    assign idx       = item.sem_id[IDX_W-1:0];
    assign cur_use   = id_ok && in_use_reg[idx];
    assign cur_avail = avail_reg[idx];
    assign cur_wpos  = wpos_reg[idx];
    assign cur_rpos  = rpos_reg[idx];
    assign cur_cnt   = cnt_reg[idx];
    assign q_full    = cur_cnt == CW'(QUEUE_DEPTH);
    assign q_empty   = cur_cnt == '0;

    always_comb begin
        do_create       = 1'b0;
        do_clear        = 1'b0;
        do_take         = 1'b0;
        do_queue        = 1'b0;
        do_wake         = 1'b0;
        do_give         = 1'b0;
        res.status      = bst_pkg::ST_OK;
        res.new_sem_id  = '0;
        res.blocked     = 1'b0;
        res.woken_valid = 1'b0;
        unique case (item.cmd)
            bst_pkg::CMD_CREATE: begin
                if (free_found) begin
                    do_create      = 1'b1;
                    res.new_sem_id = bst_pkg::FIELD_W'(free_idx);
                end else begin
                    res.status = bst_pkg::ST_NO_FREE;
                end
            end
            bst_pkg::CMD_CLEAR: begin
                if (id_ok) begin
                    do_clear = 1'b1;
                end else begin
                    res.status = bst_pkg::ST_BAD_ID;
                end
            end
            bst_pkg::CMD_DOWN: begin
                if (!cur_use) begin
                    res.status = bst_pkg::ST_BAD_ID;
                end else if (cur_avail) begin
                    do_take = 1'b1;
                end else if (q_full) begin
                    res.status = bst_pkg::ST_QUEUE_FULL;
                end else begin
                    do_queue    = 1'b1;
                    res.blocked = 1'b1;
                end
            end
            bst_pkg::CMD_UP: begin
                if (!cur_use) begin
                    res.status = bst_pkg::ST_BAD_ID;
                end else if (!q_empty) begin
                    do_wake         = 1'b1;
                    res.woken_valid = 1'b1;
                end else begin
                    do_give = 1'b1;
                end
            end
            default: begin
                res.status = bst_pkg::ST_BAD_ID;
            end
        endcase
    end

    assign ring_ctl.wr_en = en && do_queue;
    assign ring_ctl.rd_en = en && do_wake;
    assign ring_wr_addr   = {idx, cur_wpos};
    assign ring_rd_addr   = {idx, cur_rpos};
    assign ring_wr_data   = item.requester_id;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
            avail_reg  <= '0;
            for (int i = 0; i < SEM_COUNT; i++) begin
                wpos_reg[i] <= '0;
                rpos_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end else if (en) begin
            if (do_create) begin
                in_use_reg[free_idx] <= 1'b1;
                avail_reg[free_idx]  <= 1'b1;
                wpos_reg[free_idx]   <= '0;
                rpos_reg[free_idx]   <= '0;
                cnt_reg[free_idx]    <= '0;
            end
            if (do_clear) begin
                in_use_reg[idx] <= 1'b0;
            end
            if (do_take) begin
                avail_reg[idx] <= 1'b0;
            end
            if (do_give) begin
                avail_reg[idx] <= 1'b1;
            end
            if (do_queue) begin
                wpos_reg[idx] <= ring_next(cur_wpos);
                cnt_reg[idx]  <= cur_cnt + CW'(1);
            end
            if (do_wake) begin
                rpos_reg[idx] <= ring_next(cur_rpos);
                cnt_reg[idx]  <= cur_cnt - CW'(1);
            end
        end
    end

endmodule

>>> design/binary_semaphore_table.sv
`timescale 1ns / 1ps

// Table of SEM_COUNT binary semaphores, each with a FIFO of up to QUEUE_DEPTH
// waiting requester ids. One command word goes in, one result word comes out, in
// order. A command word is held in the input register, where the table lookup,
// free-entry search and state update are done, and then moves to the result
// register, which offers its result word. A new word is taken every cycle while
// the result side keeps up.
// Waiter ids live in a memory of 2**ceil(log2(SEM_COUNT)) * 2**ceil(log2(QUEUE_DEPTH))
// bytes (at least two slots per entry) with a registered read port; it needs no
// clearing after reset, so the block is ready in the first cycle after aresetn rises.
module binary_semaphore_table #(
    parameter int SEM_COUNT   = bst_pkg::SEM_COUNT_DEF,
    parameter int QUEUE_DEPTH = bst_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[1:0], sem_id[9:2], requester_id[17:10], zero[23:18]
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], new_sem_id[9:2], blocked[10], woken_valid[11],
    // woken_id[19:12], zero[23:20]
    output logic [23:0] m_tdata
);

    localparam int IDX_W = bst_pkg::clog2_min1(SEM_COUNT);
    localparam int PW    = bst_pkg::clog2_min1(QUEUE_DEPTH);
    localparam int AW    = IDX_W + PW;

    logic                        in_valid_reg;
    logic                        in_valid_next;
    bst_pkg::in_item_t           in_item_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    bst_pkg::res_t               out_res_reg;
    logic                        advance;
    logic                        s_take;
    bst_pkg::res_t               res;
    bst_pkg::ring_ctl_t          ring_ctl;
    logic [AW-1:0]               ring_wr_addr;
    logic [AW-1:0]               ring_rd_addr;
    logic [bst_pkg::FIELD_W-1:0] ring_wr_data;
    logic [bst_pkg::FIELD_W-1:0] ring_rd_data;
    logic [bst_pkg::FIELD_W-1:0] woken_id;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg.cmd          <= s_tdata[1:0];
            in_item_reg.sem_id       <= s_tdata[9:2];
            in_item_reg.requester_id <= s_tdata[17:10];
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    bst_sem_table #(
        .SEM_COUNT   (SEM_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IDX_W       (IDX_W),
        .PW          (PW)
    ) u_sem_table (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (advance),
        .item         (in_item_reg),
        .res          (res),
        .ring_ctl     (ring_ctl),
        .ring_wr_addr (ring_wr_addr),
        .ring_rd_addr (ring_rd_addr),
        .ring_wr_data (ring_wr_data)
    );

    bst_wait_ring #(
        .AW (AW)
    ) u_wait_ring (
        .aclk    (aclk),
        .ctl     (ring_ctl),
        .wr_addr (ring_wr_addr),
        .wr_data (ring_wr_data),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_rd_data)
    );

    assign woken_id = out_res_reg.woken_valid ? ring_rd_data : '0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, woken_id, out_res_reg.woken_valid, out_res_reg.blocked,
                       out_res_reg.new_sem_id, out_res_reg.status};

endmodule

>>> design/bst_port_chk.sv
`timescale 1ns / 1ps
`include "binary_semaphore_table_defines.svh"

module bst_port_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    logic [1:0] status;
    logic       blocked;
    logic       woken_valid;

    assign status      = m_tdata[1:0];
    assign blocked     = m_tdata[10];
    assign woken_valid = m_tdata[11];

    // stalled result word holds
    `BST_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a down cannot both block and wake
    `BST_ASSERT_IMP(a_block_wake_excl, aclk, aresetn, m_tvalid, !(blocked && woken_valid))

    // a failed command reports nothing else
    `BST_ASSERT_IMP(a_err_quiet, aclk, aresetn, m_tvalid && status != bst_pkg::ST_OK,
        m_tdata[11:2] == 10'd0)

    // woken id only with its valid flag
    `BST_ASSERT_IMP(a_woken_id_zero, aclk, aresetn, m_tvalid && !woken_valid,
        m_tdata[19:12] == 8'h00)

    // a word accepted while the output is empty brings m_tvalid up
    `BST_ASSERT_NXT(a_latency, aclk, aresetn, s_tvalid && s_tready && !m_tvalid, ##1 m_tvalid)

endmodule

bind binary_semaphore_table bst_port_chk u_port_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> test/bst_result_checker.sv
`timescale 1ns / 1ps

module bst_result_checker
    import bst_pkg::*;
#(
    parameter int SEM_N = SEM_COUNT_DEF,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // command[1:0], sem_id[9:2], requester_id[17:10], zero[23:18]
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], new_sem_id[9:2], blocked[10], woken_valid[11],
    // woken_id[19:12], zero[23:20]
    input  logic [23:0] m_tdata,
    output int          fail_count,
    output int          pending,
    output int          n_words,
    output int          n_blocked,
    output int          n_woken,
    output int          n_qfull,
    output int          n_nofree,
    output int          n_badid
);

    typedef struct packed {
        status_t    status;
        logic [7:0] new_sem_id;
        logic       blocked;
        logic       woken_valid;
        logic [7:0] woken_id;
    } sem_reply_t;

    bit         in_use   [SEM_N];
    bit         avail    [SEM_N];
    int         wr_pos   [SEM_N];
    int         rd_pos   [SEM_N];
    int         n_waiting[SEM_N];
    logic [7:0] waiters  [SEM_N][DEPTH];

    sem_reply_t reply_q[$];

    function automatic int ring_step(input int pos);
        return (pos + 1 >= DEPTH) ? 0 : pos + 1;
    endfunction

    function automatic sem_reply_t serve_request(input cmd_t cmd, input logic [7:0] id,
                                                 input logic [7:0] req);
        sem_reply_t r;
        bit found;
        r = '0;
        r.status = ST_OK;
        found = 1'b0;
        if (cmd == CMD_CREATE) begin
            r.status = ST_NO_FREE;
            for (int i = 0; i < SEM_N; i++) begin
                if (!found && !in_use[i]) begin
                    found = 1'b1;
                    in_use[i] = 1'b1;
                    avail[i] = 1'b1;
                    wr_pos[i] = 0;
                    rd_pos[i] = 0;
                    n_waiting[i] = 0;
                    r.status = ST_OK;
                    r.new_sem_id = 8'(i);
                end
            end
        end else if (int'(id) >= SEM_N) begin
            r.status = ST_BAD_ID;
        end else if (cmd == CMD_CLEAR) begin
            in_use[id] = 1'b0;
        end else if (!in_use[id]) begin
            r.status = ST_BAD_ID;
        end else if (cmd == CMD_DOWN) begin
            if (avail[id]) begin
                avail[id] = 1'b0;
            end else if (n_waiting[id] >= DEPTH) begin
                r.status = ST_QUEUE_FULL;
            end else begin
                waiters[id][wr_pos[id]] = req;
                wr_pos[id] = ring_step(wr_pos[id]);
                n_waiting[id]++;
                r.blocked = 1'b1;
            end
        end else begin
            if (n_waiting[id] > 0) begin
                r.woken_id = waiters[id][rd_pos[id]];
                r.woken_valid = 1'b1;
                rd_pos[id] = ring_step(rd_pos[id]);
                n_waiting[id]--;
            end else begin
                avail[id] = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report_failure(input string msg);
        $display("error at %0t: result word %0d: %s", $realtime, n_words, msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin : watch
        sem_reply_t want;
        sem_reply_t got;
        if (!aresetn) begin
            for (int i = 0; i < SEM_N; i++) begin
                in_use[i] = 1'b0;
                avail[i] = 1'b0;
                wr_pos[i] = 0;
                rd_pos[i] = 0;
                n_waiting[i] = 0;
            end
            reply_q.delete();
            pending = 0;
            fail_count = 0;
            n_words = 0;
            n_blocked = 0;
            n_woken = 0;
            n_qfull = 0;
            n_nofree = 0;
            n_badid = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                reply_q.push_back(serve_request(s_tdata[1:0], s_tdata[9:2], s_tdata[17:10]));
            end
            if (m_tvalid && m_tready) begin
                got.status      = m_tdata[1:0];
                got.new_sem_id  = m_tdata[9:2];
                got.blocked     = m_tdata[10];
                got.woken_valid = m_tdata[11];
                got.woken_id    = m_tdata[19:12];
                if (reply_q.size() == 0) begin
                    report_failure($sformatf("unexpected word 0x%06h", m_tdata));
                end else begin
                    want = reply_q.pop_front();
                    if (got.status !== want.status)
                        report_failure($sformatf("status %0d, expected %0d",
                                                 got.status, want.status));
                    if (got.new_sem_id !== want.new_sem_id)
                        report_failure($sformatf("new_sem_id %0d, expected %0d",
                                                 got.new_sem_id, want.new_sem_id));
                    if (got.blocked !== want.blocked)
                        report_failure($sformatf("blocked %0b, expected %0b",
                                                 got.blocked, want.blocked));
                    if (got.woken_valid !== want.woken_valid)
                        report_failure($sformatf("woken_valid %0b, expected %0b",
                                                 got.woken_valid, want.woken_valid));
                    if (got.woken_id !== want.woken_id)
                        report_failure($sformatf("woken_id %0d, expected %0d",
                                                 got.woken_id, want.woken_id));
                    if (want.blocked) n_blocked++;
                    if (want.woken_valid) n_woken++;
                    if (want.status == ST_QUEUE_FULL) n_qfull++;
                    if (want.status == ST_NO_FREE) n_nofree++;
                    if (want.status == ST_BAD_ID) n_badid++;
                end
                n_words++;
            end
            pending = reply_q.size();
        end
    end

endmodule

>>> test/tb_binary_semaphore_table.sv
`timescale 1ns / 1ps

module tb_binary_semaphore_table;
    import bst_pkg::*;

    localparam int SEM_N        = SEM_COUNT_DEF;
    localparam int RANDOM_ITEMS = 1450;
    localparam int HOLD_CYCLES  = 200;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // command[1:0], sem_id[9:2], requester_id[17:10], zero[23:18]
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // status[1:0], new_sem_id[9:2], blocked[10], woken_valid[11],
    // woken_id[19:12], zero[23:20]
    logic [23:0] m_tdata;

    bit gaps_on   = 1'b1;
    bit calm      = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int sent      = 0;

    int fail_count, pending, n_words, n_blocked, n_woken, n_qfull, n_nofree, n_badid;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    binary_semaphore_table u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bst_result_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .n_words    (n_words),
        .n_blocked  (n_blocked),
        .n_woken    (n_woken),
        .n_qfull    (n_qfull),
        .n_nofree   (n_nofree),
        .n_badid    (n_badid)
    );

    task automatic send_word(input cmd_t cmd, input logic [7:0] id, input logic [7:0] req);
        int gap;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, req, id, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    function automatic logic [7:0] pick_requester();
        return ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] pick_sem();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 8'($urandom_range(0, 255));
        if (r < 50) return 8'($urandom_range(0, 3));
        return 8'($urandom_range(0, SEM_N - 1));
    endfunction

    task automatic send_random();
        int r;
        cmd_t cmd;
        r = $urandom_range(0, 99);
        if (r < 15) cmd = CMD_CREATE;
        else if (r < 55) cmd = CMD_DOWN;
        else if (r < 82) cmd = CMD_UP;
        else cmd = CMD_CLEAR;
        send_word(cmd, pick_sem(), pick_requester());
    endtask

    task automatic wait_drained();
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    // receiver side: random stalls, one long hold-off on request
    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
                m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 11);
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    initial begin
        int goal;
        int r;
        int k;
        bit did_hold;
        bit did_pause;
        did_hold = 1'b0;
        did_pause = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unused and out-of-range ids on an empty table
        send_word(CMD_UP, 8'd0, 8'd1);
        send_word(CMD_DOWN, 8'd3, 8'd1);
        send_word(CMD_CLEAR, 8'd7, 8'd1);
        send_word(CMD_DOWN, 8'd16, 8'd255);
        send_word(CMD_UP, 8'd255, 8'd1);
        send_word(CMD_CLEAR, 8'd128, 8'd1);
        // take, queue two waiters incl. id zero, hand over, release
        send_word(CMD_CREATE, 8'd255, 8'd255);
        send_word(CMD_CREATE, 8'd0, 8'd0);
        send_word(CMD_DOWN, 8'd0, 8'd42);
        send_word(CMD_DOWN, 8'd0, 8'd0);
        send_word(CMD_DOWN, 8'd0, 8'd255);
        send_word(CMD_UP, 8'd0, 8'd1);
        send_word(CMD_UP, 8'd0, 8'd1);
        send_word(CMD_UP, 8'd0, 8'd1);
        send_word(CMD_DOWN, 8'd0, 8'd1);
        // clear with a waiter queued, then reallocate with an empty ring
        send_word(CMD_DOWN, 8'd1, 8'd1);
        send_word(CMD_DOWN, 8'd1, 8'd9);
        send_word(CMD_CLEAR, 8'd1, 8'd1);
        send_word(CMD_CREATE, 8'd170, 8'd85);
        send_word(CMD_UP, 8'd1, 8'd1);
        send_word(CMD_UP, 8'd1, 8'd1);
        send_word(CMD_CLEAR, 8'd15, 8'd1);

        goal = sent + RANDOM_ITEMS;
        while (sent < goal) begin
            if (!did_hold && sent >= 600) begin
                did_hold = 1'b1;
                hold_req <= 1'b1;
            end
            if (!did_pause && sent >= 900) begin
                did_pause = 1'b1;
                s_tvalid <= 1'b0;
                wait_drained();
            end
            if (sent >= goal - 150) begin
                gaps_on = 1'b0;
                calm <= 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_random();
            end else if (r < 80) begin
                // fill one wait ring past its depth, then drain it
                k = $urandom_range(0, SEM_N - 1);
                repeat (QUEUE_DEPTH_DEF + 2) send_word(CMD_DOWN, 8'(k), pick_requester());
                repeat (QUEUE_DEPTH_DEF + 2) send_word(CMD_UP, 8'(k), pick_requester());
            end else if (r < 85) begin
                repeat (SEM_N + 1) send_word(CMD_CREATE, pick_sem(), pick_requester());
            end else if (r < 90) begin
                for (int i = 0; i < SEM_N; i++) begin
                    if ($urandom_range(0, 3) != 0) send_word(CMD_CLEAR, 8'(i), pick_requester());
                end
            end else begin
                k = $urandom_range(0, SEM_N - 1);
                send_word(CMD_DOWN, 8'(k), pick_requester());
                send_word(CMD_UP, 8'(k), pick_requester());
            end
        end
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge aclk);

        $display("sent %0d command words, checked %0d results", sent, n_words);
        $display("blocked %0d, woken %0d, queue full %0d, table full %0d, bad id %0d",
                 n_blocked, n_woken, n_qfull, n_nofree, n_badid);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/bst_pkg.sv
design/bst_free_enc.sv
design/bst_wait_ring.sv
design/bst_sem_table.sv
design/binary_semaphore_table.sv
design/bst_port_chk.sv
test/bst_result_checker.sv
test/tb_binary_semaphore_table.sv
